FILE: rtl/u8tc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tc_pkg
// Shared types, constants and the high-half code table of the UTF-8 to
// 8-bit character set transcoder.
// ----------------------------------------------------------------------------
package u8tc_pkg;

   localparam int CountWidth = 16;
   localparam int CapWidth   = 16;
   localparam int CodeWidth  = 21;
   localparam int TableDepth = 128;

   localparam logic [CodeWidth-1:0] CodeMax   = 21'h10FFFF;
   localparam logic [CodeWidth-1:0] SurrLow   = 21'h00D800;
   localparam logic [CodeWidth-1:0] SurrHigh  = 21'h00DFFF;
   localparam logic [CodeWidth-1:0] MinTwo    = 21'h000080;
   localparam logic [CodeWidth-1:0] MinThree  = 21'h000800;
   localparam logic [CodeWidth-1:0] MinFour   = 21'h010000;
   localparam logic [CodeWidth-1:0] AsciiTop  = 21'h000080;

   typedef enum logic [1:0] {
      StRunning  = 2'd0,
      StComplete = 2'd1,
      StInvalid  = 2'd2,
      StFull     = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]            out_byte;
      logic                  out_valid;
      status_type            status;
      logic                  string_done;
      logic [CountWidth-1:0] out_count;
   } rsp_type;

   typedef logic [15:0] high_table_type [TableDepth];

   localparam high_table_type HighTable = '{
      16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
      16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
      16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
      16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
      16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
      16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
      16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
      16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
      16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
      16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
      16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
      16'h00FF, 16'h0178, 16'h2044, 16'h00A4, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
      16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
      16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
      16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
      16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
   };

endpackage

FILE: rtl/u8tc_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tc_map
// Maps a code point to an 8-bit character: ASCII passes through, the upper
// half is a parallel compare against the constant table.
// ----------------------------------------------------------------------------
module u8tc_map (
   input  logic [u8tc_pkg::CodeWidth-1:0] code_point,
   output logic                           hit,
   output logic [7:0]                     char_byte
);

   always_comb begin
      hit       = 1'b0;
      char_byte = 8'h00;
      if (code_point < u8tc_pkg::AsciiTop) begin
         hit       = 1'b1;
         char_byte = code_point[7:0];
      end else begin
         for (int i = 0; i < u8tc_pkg::TableDepth; i++) begin
            if (code_point == {5'b0, u8tc_pkg::HighTable[i]}) begin
               hit       = 1'b1;
               char_byte = {1'b1, 7'(i)};
            end
         end
      end
   end

endmodule

FILE: rtl/utf8_to_8bit_charset_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_8bit_charset_transcoder
// Decodes a UTF-8 byte stream, validates each character and maps it to one
// byte of an 8-bit character set, with a per-string output capacity.
// ----------------------------------------------------------------------------
//  channel | ports              | direction | payload
//  --------+--------------------+-----------+----------------------------------
//  req     | req_valid/ready    | in        | utf8_byte, last_byte
//  rsp     | rsp_valid/ready    | out       | out_byte, out_valid, status,
//          |                    |           | string_done, out_count
//  csr     | csr_we             | in        | csr_wdata = out_capacity
//
//  One byte per cycle while req_ready is high; each result is registered in the
//  result register. Decode, range checks and table compare sit between the
//  string state and the result register. A skid register keeps req_ready high
//  for one more transfer while a result is stalled. Synchronous reset clears
//  the string state and sets out_capacity to 65535.
// ----------------------------------------------------------------------------
module utf8_to_8bit_charset_transcoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_utf8_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_out_valid,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_string_done,
   output logic [u8tc_pkg::CountWidth-1:0] rsp_out_count,
   input  logic                            csr_we,
   input  logic [u8tc_pkg::CapWidth-1:0]   csr_wdata
);

   logic [u8tc_pkg::CapWidth-1:0]   capacity_ff;
   logic [u8tc_pkg::CodeWidth-1:0]  accum_ff, accum_in, accum_dec;
   logic [1:0]                      remain_ff, remain_in, remain_dec;
   logic [1:0]                      length_ff, length_in, length_dec;
   logic [u8tc_pkg::CountWidth-1:0] count_ff, count_in, count_upd;
   u8tc_pkg::status_type            sticky_ff, sticky_in, err_dec, err_upd;

   u8tc_pkg::rsp_type               out_ff, skid_ff, result;
   logic                            out_valid_ff, skid_valid_ff;

   logic                            map_hit;
   logic [7:0]                      map_byte;
   logic [u8tc_pkg::CodeWidth-1:0]  minimum;
   logic                            char_ok;
   logic                            accept, take;

   assign req_ready = !skid_valid_ff && !reset;
   assign accept    = req_valid && req_ready;
   assign take      = out_valid_ff && rsp_ready;

   // lead and continuation byte decode
   always_comb begin
      err_dec    = sticky_ff;
      accum_dec  = accum_ff;
      remain_dec = remain_ff;
      length_dec = length_ff;
      if (sticky_ff == u8tc_pkg::StRunning) begin
         if (remain_ff == 2'd0) begin
            if (count_ff >= capacity_ff) begin
               err_dec = u8tc_pkg::StFull;
            end else if (req_utf8_byte[7] == 1'b0) begin
               accum_dec  = {13'b0, req_utf8_byte};
               length_dec = 2'd0;
            end else if (req_utf8_byte[7:5] == 3'b110) begin
               accum_dec  = {16'b0, req_utf8_byte[4:0]};
               length_dec = 2'd1;
            end else if (req_utf8_byte[7:4] == 4'b1110) begin
               accum_dec  = {17'b0, req_utf8_byte[3:0]};
               length_dec = 2'd2;
            end else if (req_utf8_byte[7:3] == 5'b11110) begin
               accum_dec  = {18'b0, req_utf8_byte[2:0]};
               length_dec = 2'd3;
            end else begin
               err_dec = u8tc_pkg::StInvalid;
            end
            if (err_dec == u8tc_pkg::StRunning) begin
               remain_dec = length_dec;
            end
         end else begin
            if (req_utf8_byte[7:6] != 2'b10) begin
               err_dec = u8tc_pkg::StInvalid;
            end else begin
               accum_dec  = {accum_ff[u8tc_pkg::CodeWidth-7:0], req_utf8_byte[5:0]};
               remain_dec = remain_ff - 2'd1;
            end
         end
      end
   end

   u8tc_map u_map (
      .code_point (accum_dec),
      .hit        (map_hit),
      .char_byte  (map_byte)
   );

   always_comb begin
      unique case (length_dec)
         2'd1:    minimum = u8tc_pkg::MinTwo;
         2'd2:    minimum = u8tc_pkg::MinThree;
         2'd3:    minimum = u8tc_pkg::MinFour;
         default: minimum = '0;
      endcase
   end

   // character completion, counting and result
   always_comb begin
      err_upd   = err_dec;
      count_upd = count_ff;
      char_ok   = 1'b0;
      if (err_dec == u8tc_pkg::StRunning && remain_dec == 2'd0) begin
         if (accum_dec < minimum || accum_dec > u8tc_pkg::CodeMax ||
             (accum_dec >= u8tc_pkg::SurrLow && accum_dec <= u8tc_pkg::SurrHigh) ||
             !map_hit) begin
            err_upd = u8tc_pkg::StInvalid;
         end else begin
            char_ok = 1'b1;
            if (count_ff != '1) begin
               count_upd = count_ff + 1'b1;
            end
         end
      end
      if (err_upd == u8tc_pkg::StRunning && req_last_byte && remain_dec != 2'd0) begin
         err_upd = u8tc_pkg::StInvalid;
      end

      result.out_byte    = char_ok ? map_byte : 8'h00;
      result.out_valid   = char_ok;
      result.string_done = req_last_byte;
      result.out_count   = count_upd;
      if (err_upd != u8tc_pkg::StRunning) begin
         result.status = err_upd;
      end else if (req_last_byte) begin
         result.status = u8tc_pkg::StComplete;
      end else begin
         result.status = u8tc_pkg::StRunning;
      end

      // clear per-string state on the last byte
      if (req_last_byte) begin
         accum_in  = '0;
         remain_in = 2'd0;
         length_in = 2'd0;
         count_in  = '0;
         sticky_in = u8tc_pkg::StRunning;
      end else begin
         accum_in  = accum_dec;
         remain_in = remain_dec;
         length_in = length_dec;
         count_in  = count_upd;
         sticky_in = err_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '1;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff  <= '0;
         remain_ff <= 2'd0;
         length_ff <= 2'd0;
         count_ff  <= '0;
         sticky_ff <= u8tc_pkg::StRunning;
      end else if (accept) begin
         accum_ff  <= accum_in;
         remain_ff <= remain_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
   end

   // result register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_valid_ff || take) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end else if (take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_ff.out_byte;
   assign rsp_out_valid   = out_ff.out_valid;
   assign rsp_status      = out_ff.status;
   assign rsp_string_done = out_ff.string_done;
   assign rsp_out_count   = out_ff.out_count;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a transfer while the result register is empty");

   a_char_status : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.out_valid) |->
         (out_ff.status == u8tc_pkg::StRunning || out_ff.status == u8tc_pkg::StComplete))
      else $error("character emitted with an error status");

   a_char_counted : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.out_valid) |-> (out_ff.out_count != '0))
      else $error("character emitted without a count");

   a_string_clear : assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=>
         (count_ff == '0 && remain_ff == 2'd0 && sticky_ff == u8tc_pkg::StRunning))
      else $error("string state not cleared after the last byte");

endmodule
